// ===== rtl/core/lodd_pkg.sv =====
// ----------------------------------------------------------------------------
// lodd_pkg
// shared sizes, types and codes for the lock order deadlock detector
// ----------------------------------------------------------------------------
package lodd_pkg;

    localparam int NUM_LOCKS   = 8;
    localparam int NUM_THREADS = 8;

    // field widths of the event word
    localparam int THREAD_W = 3;
    localparam int LOCK_W   = 3;

    // closure round counter
    localparam int ROUND_W = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;

    typedef logic [THREAD_W-1:0]  thread_id_t;
    typedef logic [LOCK_W-1:0]    lock_id_t;
    typedef logic [NUM_LOCKS-1:0] lock_vec_t;

    typedef enum logic
    {
        ACT_ACQUIRE = 1'b0,
        ACT_RELEASE = 1'b1
    } action_t;

    // commands from the controller to the datapath
    typedef struct packed
    {
        logic load;   // apply the event and seed the reach matrix
        logic step;   // one closure round
        logic store;  // latch the result word
    } lodd_cmd_t;

endpackage

// ===== rtl/core/lodd_if.sv =====
// ----------------------------------------------------------------------------
// lodd_event_if / lodd_result_if
// valid/ready channels for lock events and detector results
// ----------------------------------------------------------------------------
interface lodd_event_if;
    logic                 valid;
    logic                 ready;
    lodd_pkg::action_t    action;
    lodd_pkg::thread_id_t thread_id;
    lodd_pkg::lock_id_t   lock_id;

    modport source (output valid, output action, output thread_id, output lock_id,
                    input ready);
    modport sink   (input valid, input action, input thread_id, input lock_id,
                    output ready);
endinterface

interface lodd_result_if;
    logic valid;
    logic ready;
    logic cycle_found;
    logic new_edge;

    modport source (output valid, output cycle_found, output new_edge, input ready);
    modport sink   (input valid, input cycle_found, input new_edge, output ready);
endinterface

// ===== rtl/core/lock_order_deadlock_detector_core.sv =====
// ----------------------------------------------------------------------------
// lock_order_deadlock_detector_core
// lock-order graph builder with transitive closure and cycle report
// ----------------------------------------------------------------------------
//  channel  dir  payload                      handshake
//  evt      in   action, thread_id, lock_id   valid/ready, taken when both high
//  res      out  cycle_found, new_edge        valid/ready, taken when both high
//
//  one event word at a time: the accept cycle updates the held sets and the
//  order matrix, then NUM_LOCKS closure rounds run (one row-OR round per cycle),
//  and then the result register is written. the result register holds a
//  finished word while the next event is taken; a stalled res stops the
//  sequencer only when the next result is due.
//  reset clears all held sets, all order edges and the result valid.
// ----------------------------------------------------------------------------
module lock_order_deadlock_detector_core
(
    input  logic         clk,
    input  logic         rst_n,
    lodd_event_if.sink   evt,
    lodd_result_if.source res
);
    import lodd_pkg::*;

    lodd_cmd_t cmd;

    // sequencer: owns the round counter and the result valid
    lodd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (evt.valid),
        .in_ready  (evt.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .cmd       (cmd)
    );

    // graph state and closure; event fields are read on the accept cycle only
    lodd_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .action      (evt.action),
        .thread_id   (evt.thread_id),
        .lock_id     (evt.lock_id),
        .cycle_found (res.cycle_found),
        .new_edge    (res.new_edge)
    );

endmodule

// ===== rtl/core/lodd_ctrl.sv =====
// ----------------------------------------------------------------------------
// lodd_ctrl
// sequencer: event accept, closure rounds, result hand-off
// ----------------------------------------------------------------------------
module lodd_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output lodd_pkg::lodd_cmd_t cmd
);
    import lodd_pkg::*;

    typedef enum logic [3:0]
    {
        S_IDLE   = 4'b0001,
        S_ROUND  = 4'b0010,
        S_FINISH = 4'b0100,
        S_SPARE  = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic               out_valid_reg, out_valid_next;
    logic               accept;
    logic               store;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign store     = (state_reg == S_FINISH) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_ROUND;
                    round_next = '0;
                end
            end
            S_ROUND:
            begin
                if (round_reg == ROUND_W'(NUM_LOCKS - 1))
                    state_next = S_FINISH;
                else
                    round_next = round_reg + 1'b1;
            end
            S_FINISH:
            begin
                if (store)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (store)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign cmd.load  = accept;
    assign cmd.step  = (state_reg == S_ROUND);
    assign cmd.store = store;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/core/lodd_datapath.sv =====
// ----------------------------------------------------------------------------
// lodd_datapath
// held-lock sets, lock-order matrix, reach matrix and result word
// ----------------------------------------------------------------------------
module lodd_datapath
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lodd_pkg::lodd_cmd_t  cmd,
    input  lodd_pkg::action_t    action,
    input  lodd_pkg::thread_id_t thread_id,
    input  lodd_pkg::lock_id_t   lock_id,
    output logic                 cycle_found,
    output logic                 new_edge
);
    import lodd_pkg::*;

    lock_vec_t held_reg  [NUM_THREADS];
    lock_vec_t edge_reg  [NUM_LOCKS];
    lock_vec_t edge_next [NUM_LOCKS];
    lock_vec_t reach_reg [NUM_LOCKS];
    lock_vec_t reach_step[NUM_LOCKS];
    logic      added_reg;
    logic      cycle_found_reg;
    logic      new_edge_reg;

    logic      in_range;
    logic      acquire;
    lock_vec_t lock_bit;
    lock_vec_t held_row;
    lock_vec_t lock_col;
    lock_vec_t diag;
    logic      added;

    assign in_range = (int'(thread_id) < NUM_THREADS) && (int'(lock_id) < NUM_LOCKS);
    assign acquire  = in_range && (action == ACT_ACQUIRE);
    assign lock_bit = lock_vec_t'(1) << lock_id;
    assign held_row = held_reg[thread_id];

    // column of the new lock: which locks already order before it
    always_comb
    begin
        for (int i = 0; i < NUM_LOCKS; i++)
        begin
            lock_col[i]  = edge_reg[i][lock_id];
            edge_next[i] = edge_reg[i] | ((acquire && held_row[i]) ? lock_bit : '0);
            diag[i]      = reach_reg[i][i];
        end
    end

    assign added = acquire && (|(held_row & ~lock_col));

    // one closure round, all rows at once
    always_comb
    begin
        for (int i = 0; i < NUM_LOCKS; i++)
        begin
            reach_step[i] = reach_reg[i];
            for (int j = 0; j < NUM_LOCKS; j++)
            begin
                if (reach_reg[i][j])
                    reach_step[i] = reach_step[i] | reach_reg[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < NUM_THREADS; t++)
                held_reg[t] <= '0;
            for (int i = 0; i < NUM_LOCKS; i++)
                edge_reg[i] <= '0;
        end
        else if (cmd.load)
        begin
            for (int i = 0; i < NUM_LOCKS; i++)
                edge_reg[i] <= edge_next[i];
            if (acquire)
                held_reg[thread_id] <= held_row | lock_bit;
            else if (in_range)
                held_reg[thread_id] <= held_row & ~lock_bit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            added_reg <= added;
            for (int i = 0; i < NUM_LOCKS; i++)
                reach_reg[i] <= edge_next[i];
        end
        else if (cmd.step)
        begin
            for (int i = 0; i < NUM_LOCKS; i++)
                reach_reg[i] <= reach_step[i];
        end
        if (cmd.store)
        begin
            cycle_found_reg <= |diag;
            new_edge_reg    <= added_reg;
        end
    end

    assign cycle_found = cycle_found_reg;
    assign new_edge    = new_edge_reg;

endmodule

// ===== verif/lodd_scoreboard_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lodd_scoreboard_pkg
// predicts the detector's result word for every lock event taken and checks
// each result word the block returns against the oldest prediction
// ----------------------------------------------------------------------------
package lodd_scoreboard_pkg;

    import lodd_pkg::*;

    typedef struct packed
    {
        logic cycle_found;
        logic new_edge;
    } lodd_verdict_t;

    class lodd_scoreboard;

        lock_vec_t     held_sets [NUM_THREADS];
        lock_vec_t     order_rows [NUM_LOCKS];
        lodd_verdict_t verdict_q [$];
        int unsigned   errors;
        int unsigned   events_taken;
        int unsigned   words_checked;
        int unsigned   cycle_words;
        int unsigned   edge_words;

        function new();
            foreach (held_sets[t]) held_sets[t] = '0;
            foreach (order_rows[l]) order_rows[l] = '0;
            errors        = 0;
            events_taken  = 0;
            words_checked = 0;
            cycle_words   = 0;
            edge_words    = 0;
        endfunction

        // closure by successive intermediate locks, then look at the diagonal
        function bit graph_loops();
            lock_vec_t reach [NUM_LOCKS];
            bit        loops;
            loops = 1'b0;
            foreach (order_rows[l]) reach[l] = order_rows[l];
            for (int k = 0; k < NUM_LOCKS; k++)
                for (int i = 0; i < NUM_LOCKS; i++)
                    if (reach[i][k])
                        reach[i] |= reach[k];
            for (int i = 0; i < NUM_LOCKS; i++)
                if (reach[i][i])
                    loops = 1'b1;
            return loops;
        endfunction

        function void note_event(action_t action, thread_id_t thread_id, lock_id_t lock_id);
            lock_vec_t     lock_bit;
            lodd_verdict_t verdict;
            verdict.new_edge = 1'b0;
            lock_bit = lock_vec_t'(1) << lock_id;
            events_taken++;
            // out of range indexes leave the state alone
            if (int'(thread_id) < NUM_THREADS && int'(lock_id) < NUM_LOCKS)
            begin
                if (action == ACT_ACQUIRE)
                begin
                    for (int i = 0; i < NUM_LOCKS; i++)
                        if (held_sets[thread_id][i])
                        begin
                            if (!order_rows[i][lock_id])
                                verdict.new_edge = 1'b1;
                            order_rows[i] |= lock_bit;
                        end
                    held_sets[thread_id] |= lock_bit;
                end
                else
                begin
                    held_sets[thread_id] &= ~lock_bit;
                end
            end
            verdict.cycle_found = graph_loops();
            verdict_q.push_back(verdict);
        endfunction

        function void check_result(logic cycle_found, logic new_edge);
            lodd_verdict_t want;
            if (verdict_q.size() == 0)
            begin
                $error("result word with nothing expected: cycle_found=%0b new_edge=%0b",
                       cycle_found, new_edge);
                errors++;
                return;
            end
            want = verdict_q.pop_front();
            words_checked++;
            if (cycle_found === 1'b1) cycle_words++;
            if (new_edge === 1'b1) edge_words++;
            if (cycle_found !== want.cycle_found)
            begin
                $error("cycle_found mismatch: expected %0b, got %0b",
                       want.cycle_found, cycle_found);
                errors++;
            end
            if (new_edge !== want.new_edge)
            begin
                $error("new_edge mismatch: expected %0b, got %0b", want.new_edge, new_edge);
                errors++;
            end
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction

    endclass

endpackage

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// lock event stream into the deadlock detector, result words checked in order
// against a predictor of the held sets and the lock-order graph; directed
// events first, then ordered nesting, then cycle forming and mixed traffic
// ----------------------------------------------------------------------------
module tb;

    import lodd_pkg::*;
    import lodd_scoreboard_pkg::*;

    localparam int ORDERED_EVENTS   = 900;   // nesting in ascending lock order, no cycle
    localparam int MIXED_EVENTS     = 900;   // any order plus noise
    localparam int CALM_EVENTS      = 200;   // tail of the mixed part with no idling
    localparam int LONG_HOLD_CYCLES = 300;   // receiver hold-off for the back-pressure case
    localparam int STALL_LIMIT      = 3000;  // cycles without any word moving
    localparam int TAIL_CYCLES      = 40;    // wait after the last word

    logic clk;
    logic rst_n;

    lodd_event_if  evt_if ();
    lodd_result_if res_if ();

    lock_order_deadlock_detector_core u_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt_if),
        .res   (res_if)
    );

    lodd_scoreboard sb;

    // what each thread holds, from the stimulus side, to shape well-formed nesting
    lock_vec_t gen_held [NUM_THREADS];

    // idling controls, switched off in the last part of the run
    bit tx_gaps_on;
    bit rx_stalls_on;
    bit long_hold_req;

    // 20 ns clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // monitor: every word that moves is seen at the rising edge; an accepted
    // event feeds the predictor, an accepted result word is checked
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (evt_if.valid && evt_if.ready)
                sb.note_event(evt_if.action, evt_if.thread_id, evt_if.lock_id);
            if (res_if.valid && res_if.ready)
                sb.check_result(res_if.cycle_found, res_if.new_edge);
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: ends the run when nothing moves for too long
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (evt_if.valid && evt_if.ready) || (res_if.valid && res_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // result receiver: ready stretches, random stall bursts and one long
    // hold-off on request; the hold is counted here
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (rx_stalls_on && $urandom_range(0, 5) == 0)
            begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 12) - 1) @(negedge clk);
            end
            else
            begin
                res_if.ready <= 1'b1;
                repeat ($urandom_range(0, 15)) @(negedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // sender: one event word per call, with an optional random gap before it;
    // valid stays high across back-to-back words
    // ------------------------------------------------------------------------
    task automatic send_lock_event(input action_t act, input thread_id_t tid,
                                   input lock_id_t lock);
        int gap;
        if (tx_gaps_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            evt_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        evt_if.valid     <= 1'b1;
        evt_if.action    <= act;
        evt_if.thread_id <= tid;
        evt_if.lock_id   <= lock;
        @(posedge clk);
        while (!evt_if.ready) @(posedge clk);
        // keep the stimulus-side view of the held sets in step
        if (act == ACT_ACQUIRE)
            gen_held[tid][lock] = 1'b1;
        else
            gen_held[tid][lock] = 1'b0;
    endtask

    // picks a well-formed event: acquire a free lock or release a held one;
    // in ordered mode new locks always sit above everything the thread holds,
    // so the graph stays acyclic
    function automatic void pick_event(input bit ordered, output action_t act,
                                       output thread_id_t tid, output lock_id_t lock);
        lock_vec_t held;
        int        top;
        bit        room;
        tid  = thread_id_t'($urandom_range(0, NUM_THREADS - 1));
        held = gen_held[tid];
        top  = -1;
        for (int l = 0; l < NUM_LOCKS; l++)
            if (held[l])
                top = l;
        room = ordered ? (top < NUM_LOCKS - 1) : (held != '1);
        if (held == '0)
            act = ACT_ACQUIRE;
        else if (room && $urandom_range(0, 2) != 0)
            act = ACT_ACQUIRE;
        else
            act = ACT_RELEASE;
        if (act == ACT_ACQUIRE && ordered)
            lock = lock_id_t'($urandom_range(top + 1, NUM_LOCKS - 1));
        else if (act == ACT_ACQUIRE)
            do lock = lock_id_t'($urandom_range(0, NUM_LOCKS - 1)); while (held[lock]);
        else
            do lock = lock_id_t'($urandom_range(0, NUM_LOCKS - 1)); while (!held[lock]);
    endfunction

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main
        action_t    act;
        thread_id_t tid;
        lock_id_t   lock;

        sb = new();
        foreach (gen_held[t]) gen_held[t] = '0;
        tx_gaps_on       = 1'b1;
        rx_stalls_on     = 1'b1;
        long_hold_req    = 1'b0;
        evt_if.valid     = 1'b0;
        evt_if.action    = ACT_ACQUIRE;
        evt_if.thread_id = '0;
        evt_if.lock_id   = '0;
        rst_n            = 1'b0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed, all acyclic: extreme thread and lock indexes, an edge
        // that already exists, release out of nesting order, release of a
        // lock that is not held, and a deep nest on one thread
        send_lock_event(ACT_ACQUIRE, 3'd0, 3'd0);
        send_lock_event(ACT_ACQUIRE, 3'd0, 3'd7);    // first edge 0 -> 7
        send_lock_event(ACT_RELEASE, 3'd0, 3'd7);
        send_lock_event(ACT_ACQUIRE, 3'd0, 3'd7);    // same edge again, nothing new
        send_lock_event(ACT_RELEASE, 3'd0, 3'd7);
        send_lock_event(ACT_RELEASE, 3'd0, 3'd0);
        send_lock_event(ACT_ACQUIRE, 3'd7, 3'd3);
        send_lock_event(ACT_ACQUIRE, 3'd7, 3'd5);
        send_lock_event(ACT_RELEASE, 3'd7, 3'd3);    // outer lock let go first
        send_lock_event(ACT_RELEASE, 3'd7, 3'd3);    // not held any more
        send_lock_event(ACT_RELEASE, 3'd7, 3'd5);
        send_lock_event(ACT_RELEASE, 3'd5, 3'd6);    // thread never held it
        send_lock_event(ACT_ACQUIRE, 3'd2, 3'd1);
        send_lock_event(ACT_ACQUIRE, 3'd2, 3'd2);
        send_lock_event(ACT_ACQUIRE, 3'd2, 3'd4);
        send_lock_event(ACT_ACQUIRE, 3'd2, 3'd6);
        send_lock_event(ACT_RELEASE, 3'd2, 3'd6);
        send_lock_event(ACT_RELEASE, 3'd2, 3'd4);
        send_lock_event(ACT_RELEASE, 3'd2, 3'd2);
        send_lock_event(ACT_RELEASE, 3'd2, 3'd1);

        // ordered nesting across threads; the graph grows but never loops
        for (int n = 0; n < ORDERED_EVENTS; n++)
        begin
            // long receiver hold while events keep coming, so the block backs up
            if (n == 300)
                long_hold_req = 1'b1;
            // sender drops valid and waits for every outstanding result word once
            if (n == 600)
            begin
                @(negedge clk);
                evt_if.valid <= 1'b0;
                while (sb.pending() != 0) @(posedge clk);
            end
            pick_event(1'b1, act, tid, lock);
            send_lock_event(act, tid, lock);
        end

        // drop every held lock, then close a loop by lock inversion and
        // add a self edge by taking a lock the thread already holds
        for (int t = 0; t < NUM_THREADS; t++)
            for (int l = 0; l < NUM_LOCKS; l++)
                if (gen_held[t][l])
                    send_lock_event(ACT_RELEASE, thread_id_t'(t), lock_id_t'(l));
        send_lock_event(ACT_ACQUIRE, 3'd3, 3'd6);
        send_lock_event(ACT_ACQUIRE, 3'd3, 3'd1);    // 6 -> 1 against the usual order
        send_lock_event(ACT_ACQUIRE, 3'd3, 3'd1);    // re-acquire, self edge
        send_lock_event(ACT_RELEASE, 3'd3, 3'd1);
        send_lock_event(ACT_RELEASE, 3'd3, 3'd6);

        // any nesting order with some noise; the tail runs without idling
        for (int n = 0; n < MIXED_EVENTS; n++)
        begin
            if (n == MIXED_EVENTS - CALM_EVENTS)
            begin
                tx_gaps_on   = 1'b0;
                rx_stalls_on = 1'b0;
            end
            if ($urandom_range(0, 9) < 7)
            begin
                pick_event(1'b0, act, tid, lock);
            end
            else
            begin
                act  = action_t'($urandom_range(0, 1));
                tid  = thread_id_t'($urandom_range(0, NUM_THREADS - 1));
                lock = lock_id_t'($urandom_range(0, NUM_LOCKS - 1));
            end
            send_lock_event(act, tid, lock);
        end
        @(negedge clk);
        evt_if.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d lock events and %0d result words through stalls and gaps",
                 sb.events_taken, sb.words_checked);
        $display("words reporting a cycle: %0d, words reporting a new order edge: %0d",
                 sb.cycle_words, sb.edge_words);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/lodd_pkg.sv
rtl/core/lodd_if.sv
rtl/core/lodd_ctrl.sv
rtl/core/lodd_datapath.sv
rtl/core/lock_order_deadlock_detector_core.sv
verif/lodd_scoreboard_pkg.sv
verif/tb.sv
